// File: rtl/kspf_pkg.sv
// kspf_pkg: shared constants, payload structs and sequencer codes
// for the keypad scanner with press queue; no dependencies
package kspf_pkg;

  // sizing
  localparam int unsigned QUEUE_DEPTH = 128;
  localparam int unsigned NUM_COLS    = 4;
  localparam int unsigned NUM_ROWS    = 4;

  // key code layout is fixed: two row bits over two column bits
  localparam int unsigned KEY_W   = 4;
  localparam int unsigned LINE_W  = 2;
  localparam int unsigned MASK_W  = 16;
  localparam int unsigned FILL_OW = 8;

  localparam int unsigned IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W  = FILL_W + 1;

  // request function codes
  localparam logic FUNC_SCAN = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [MASK_W-1:0] matrix_sample;
    logic [KEY_W-1:0]  query_key;
  } kspf_in_t;

  typedef struct packed {
    logic               key_valid;
    logic [KEY_W-1:0]   key_code;
    logic               key_held;
    logic               any_held;
    logic [FILL_OW-1:0] queue_fill;
  } kspf_out_t;

  // sequencer to ring
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [KEY_W-1:0] code;
  } kspf_ring_req_t;

  // ring to sequencer
  typedef struct packed {
    logic              empty;
    logic [FILL_W-1:0] fill;
    logic [KEY_W-1:0]  rd_code;
  } kspf_ring_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_POP  = 4'b0100,
    ST_DONE = 4'b1000
  } kspf_state_e;

endpackage

// File: rtl/kspf_ring.sv
// kspf_ring: single-port key ring with head pointer and fill count,
// overwriting the oldest entry when full; uses kspf_pkg
module kspf_ring (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  kspf_pkg::kspf_ring_req_t req_i,
  output kspf_pkg::kspf_ring_stat_t stat_o
);

  logic [kspf_pkg::KEY_W-1:0]  mem [kspf_pkg::QUEUE_DEPTH];
  logic [kspf_pkg::KEY_W-1:0]  rd_code_q;
  logic [kspf_pkg::IDX_W-1:0]  head_q, head_d, head_inc;
  logic [kspf_pkg::FILL_W-1:0] fill_q, fill_d;
  logic [kspf_pkg::SUM_W-1:0]  slot_sum;
  logic [kspf_pkg::IDX_W-1:0]  slot;
  logic                        full, empty;

  assign full  = (fill_q == kspf_pkg::FILL_W'(kspf_pkg::QUEUE_DEPTH));
  assign empty = (fill_q == '0);

  // head wraps at the ring depth
  assign head_inc = (head_q == kspf_pkg::IDX_W'(kspf_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : head_q + kspf_pkg::IDX_W'(1);

  // tail slot: head plus fill, folded once into the ring
  assign slot_sum = kspf_pkg::SUM_W'(head_q) + kspf_pkg::SUM_W'(fill_q);
  assign slot     = (slot_sum >= kspf_pkg::SUM_W'(kspf_pkg::QUEUE_DEPTH)) ?
                    kspf_pkg::IDX_W'(slot_sum - kspf_pkg::SUM_W'(kspf_pkg::QUEUE_DEPTH)) :
                    kspf_pkg::IDX_W'(slot_sum);

  // pointer update
  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (req_i.push) begin
      if (full) begin
        head_d = head_inc;
      end else begin
        fill_d = fill_q + kspf_pkg::FILL_W'(1);
      end
    end else if (req_i.pop && !empty) begin
      head_d = head_inc;
      fill_d = fill_q - kspf_pkg::FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  // storage: write at tail on push, registered read at head on pop
  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem[slot] <= req_i.code;
    end
    if (req_i.pop) begin
      rd_code_q <= mem[head_q];
    end
  end

  assign stat_o.empty   = empty;
  assign stat_o.fill    = fill_q;
  assign stat_o.rd_code = rd_code_q;

endmodule

// File: rtl/keypad_scan_press_fifo.sv
// keypad_scan_press_fifo: top level, request sequencer with a shared
// column evaluator and output register; uses kspf_pkg and kspf_ring
//
//  channel | signals                         | payload
//  --------+---------------------------------+--------------------------
//  in      | in_valid_i / in_ready_o         | in_req_i  (kspf_in_t)
//  out     | out_valid_o / out_ready_i       | out_rsp_o (kspf_out_t)
//
// a scan request steps through accept, one column per cycle through the
// shared column evaluator, and finish; a pop steps through accept, ring
// read and finish. reset clears the held mask, ring pointers and fill;
// ring contents are not cleared. a result waiting in the output register
// does not block the next request; only the finish step waits for the
// register to free.
module keypad_scan_press_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  kspf_pkg::kspf_in_t in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output kspf_pkg::kspf_out_t out_rsp_o
);

  kspf_pkg::kspf_state_e state_q, state_d;

  logic [kspf_pkg::MASK_W-1:0] sample_q;
  logic [kspf_pkg::KEY_W-1:0]  query_q;
  logic                        func_q;
  logic [kspf_pkg::LINE_W-1:0] col_q, col_d;
  logic [kspf_pkg::MASK_W-1:0] found_q, found_d;
  logic [kspf_pkg::MASK_W-1:0] held_q, held_d;
  logic                        pop_hit_q, pop_hit_d;

  logic                        out_valid_q, out_valid_d;
  kspf_pkg::kspf_out_t         out_q, out_d;

  kspf_pkg::kspf_ring_req_t    ring_req;
  kspf_pkg::kspf_ring_stat_t   ring_stat;

  logic                        accept;
  logic                        last_col;
  logic                        pick_found;
  logic [kspf_pkg::LINE_W-1:0] pick_row;
  logic [kspf_pkg::KEY_W-1:0]  pick_code;
  logic [kspf_pkg::MASK_W-1:0] pick_bit;
  logic                        finish;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == kspf_pkg::ST_IDLE);
  assign last_col   = (col_q == kspf_pkg::LINE_W'(kspf_pkg::NUM_COLS - 1));

  // column evaluator: last pressed row of the current column wins
  always_comb begin
    pick_found = 1'b0;
    pick_row   = '0;
    for (int r = 0; r < kspf_pkg::NUM_ROWS; r++) begin
      if (sample_q[{kspf_pkg::LINE_W'(r), col_q}]) begin
        pick_found = 1'b1;
        pick_row   = kspf_pkg::LINE_W'(r);
      end
    end
  end

  assign pick_code = {pick_row, col_q};
  assign pick_bit  = kspf_pkg::MASK_W'(1) << pick_code;

  // finish step may load the output register once it is free
  assign finish = (state_q == kspf_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    found_d      = found_q;
    held_d       = held_q;
    pop_hit_d    = pop_hit_q;
    ring_req     = '0;
    ring_req.code = pick_code;
    unique case (state_q)
      kspf_pkg::ST_IDLE: begin
        if (accept) begin
          col_d   = '0;
          found_d = '0;
          state_d = (in_req_i.func == kspf_pkg::FUNC_POP) ?
                    kspf_pkg::ST_POP : kspf_pkg::ST_SCAN;
        end
      end
      kspf_pkg::ST_SCAN: begin
        if (pick_found) begin
          found_d       = found_q | pick_bit;
          ring_req.push = !held_q[pick_code];
        end
        col_d = col_q + kspf_pkg::LINE_W'(1);
        if (last_col) begin
          held_d  = found_d;
          state_d = kspf_pkg::ST_DONE;
        end
      end
      kspf_pkg::ST_POP: begin
        ring_req.pop = !ring_stat.empty;
        pop_hit_d    = !ring_stat.empty;
        state_d      = kspf_pkg::ST_DONE;
      end
      kspf_pkg::ST_DONE: begin
        if (finish) begin
          state_d = kspf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kspf_pkg::ST_IDLE;
      end
    endcase
  end

  // result assembly and output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (finish) begin
      out_valid_d         = 1'b1;
      out_d.key_valid     = (func_q == kspf_pkg::FUNC_POP) && pop_hit_q;
      out_d.key_code      = out_d.key_valid ? ring_stat.rd_code : '0;
      out_d.key_held      = held_q[query_q];
      out_d.any_held      = |held_q;
      out_d.queue_fill    = kspf_pkg::FILL_OW'(ring_stat.fill);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kspf_pkg::ST_IDLE;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= in_req_i.func;
      sample_q <= in_req_i.matrix_sample;
      query_q  <= in_req_i.query_key;
    end
    col_q     <= col_d;
    found_q   <= found_d;
    pop_hit_q <= pop_hit_d;
    out_q     <= out_d;
  end

  kspf_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ring_req),
    .stat_o (ring_stat)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // checks

  // the ring is never asked to push and pop in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ring_req.push && ring_req.pop))
    else $error("ring push and pop together");

  // fill never exceeds the ring depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_stat.fill <= kspf_pkg::FILL_W'(kspf_pkg::QUEUE_DEPTH))
    else $error("ring fill above depth");

  // an accepted request keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("ready right after accept");

  // a result without a popped key carries a zero code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_rsp_o.key_valid) |-> (out_rsp_o.key_code == '0))
    else $error("nonzero code without key");

endmodule

// File: sim/keypad_scan_press_fifo_tb.sv
`timescale 1ns / 1ps
// keypad_scan_press_fifo_tb: self-checking bench for the keypad scanner with press queue,
// predicts each report from its own held mask and key ring; uses kspf_pkg and the top level
module keypad_scan_press_fifo_tb;

  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 20;

  // clock, reset and block ports
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready_o;
  kspf_pkg::kspf_in_t  in_req = '0;
  logic                out_valid_o;
  logic                out_ready = 1'b0;
  kspf_pkg::kspf_out_t out_rsp_o;

  // request stream and expected reports
  kspf_pkg::kspf_in_t  key_requests[$];
  kspf_pkg::kspf_out_t expected_reports[$];
  kspf_pkg::kspf_out_t next_report;
  int unsigned         reqs_made = 0;
  int unsigned         mismatches = 0;

  // idling control, set per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  int unsigned hold_cnt = 0;

  // predicted scanner state
  logic [kspf_pkg::MASK_W-1:0]  held_keys;
  logic [kspf_pkg::KEY_W-1:0]   press_ring [kspf_pkg::QUEUE_DEPTH];
  logic [kspf_pkg::IDX_W-1:0]   ring_head;
  logic [kspf_pkg::FILL_OW-1:0] ring_fill;

  always #10 clk_i = ~clk_i;

  keypad_scan_press_fifo DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp_o)
  );

  // one request applied to the predicted state, returns the report it yields
  function automatic kspf_pkg::kspf_out_t keypad_report(input kspf_pkg::kspf_in_t req);
    kspf_pkg::kspf_out_t         rsp;
    logic [kspf_pkg::MASK_W-1:0] found;
    int                          pick;
    int                          code;
    int                          slot;
    rsp = '0;
    if (req.func == kspf_pkg::FUNC_SCAN) begin
      found = '0;
      for (int col = 0; col < kspf_pkg::NUM_COLS; col++) begin
        // highest pressed row in the column wins
        pick = -1;
        for (int row = 0; row < kspf_pkg::NUM_ROWS; row++) begin
          if (req.matrix_sample[4 * row + col]) pick = row;
        end
        if (pick >= 0) begin
          code = 4 * pick + col;
          if (!held_keys[code]) begin
            slot = (int'(ring_head) + int'(ring_fill)) % kspf_pkg::QUEUE_DEPTH;
            press_ring[slot] = kspf_pkg::KEY_W'(code);
            // full ring drops its oldest key
            if (ring_fill >= kspf_pkg::QUEUE_DEPTH)
              ring_head = kspf_pkg::IDX_W'((ring_head + 1) % kspf_pkg::QUEUE_DEPTH);
            else ring_fill = ring_fill + 1'b1;
          end
          found[code] = 1'b1;
        end
      end
      held_keys = found;
    end else if (ring_fill != 0) begin
      rsp.key_valid = 1'b1;
      rsp.key_code  = press_ring[ring_head];
      ring_head     = kspf_pkg::IDX_W'((ring_head + 1) % kspf_pkg::QUEUE_DEPTH);
      ring_fill     = ring_fill - 1'b1;
    end
    rsp.key_held   = held_keys[req.query_key];
    rsp.any_held   = |held_keys;
    rsp.queue_fill = ring_fill;
    return rsp;
  endfunction

  function automatic void add_req(input logic func,
                                  input logic [kspf_pkg::MASK_W-1:0] sample,
                                  input logic [kspf_pkg::KEY_W-1:0] query);
    kspf_pkg::kspf_in_t req;
    req.func          = func;
    req.matrix_sample = sample;
    req.query_key     = query;
    key_requests.push_back(req);
    reqs_made++;
  endfunction

  function automatic logic [kspf_pkg::MASK_W-1:0] rand_mask(input int unsigned pct);
    logic [kspf_pkg::MASK_W-1:0] m;
    for (int b = 0; b < kspf_pkg::MASK_W; b++) m[b] = ($urandom_range(0, 99) < pct);
    return m;
  endfunction

  function automatic logic [kspf_pkg::KEY_W-1:0] rand_key();
    return kspf_pkg::KEY_W'($urandom_range(0, 15));
  endfunction

  // mixed traffic: press and hold, scan bursts, pop bursts and noise
  task automatic add_random_traffic(input int unsigned count);
    int unsigned                 target;
    int unsigned                 len;
    logic [kspf_pkg::MASK_W-1:0] pressed;
    target = reqs_made + count;
    while (reqs_made < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // key press held over a few scans, with some bounce, then release
          pressed = rand_mask(20);
          len = $urandom_range(1, 4);
          repeat (len) begin
            if ($urandom_range(0, 3) == 0)
              add_req(kspf_pkg::FUNC_SCAN, pressed ^ (16'h1 << $urandom_range(0, 15)),
                      rand_key());
            else
              add_req(kspf_pkg::FUNC_SCAN, pressed, rand_key());
            if ($urandom_range(0, 2) == 0)
              add_req(kspf_pkg::FUNC_POP, kspf_pkg::MASK_W'($urandom), rand_key());
          end
          if ($urandom_range(0, 1) == 0) add_req(kspf_pkg::FUNC_SCAN, '0, rand_key());
        end
        4, 5: begin
          // dense scans against releases to fill and overrun the ring
          len = $urandom_range(20, 40);
          repeat (len) begin
            add_req(kspf_pkg::FUNC_SCAN, rand_mask(50), rand_key());
            add_req(kspf_pkg::FUNC_SCAN, ($urandom_range(0, 1) == 0) ? '0 : rand_mask(10),
                    rand_key());
          end
        end
        6, 7: begin
          // drain, often past empty
          len = $urandom_range(10, 150);
          repeat (len) add_req(kspf_pkg::FUNC_POP, kspf_pkg::MASK_W'($urandom), rand_key());
        end
        default: begin
          len = $urandom_range(5, 20);
          repeat (len)
            add_req(logic'($urandom_range(0, 1)), kspf_pkg::MASK_W'($urandom), rand_key());
        end
      endcase
    end
  endtask

  task automatic note_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %0d actual %0d", field, want, got);
  endtask

  // driver: offer the next request, predict on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      in_req    <= '0;
      held_keys = '0;
      ring_head = '0;
      ring_fill = '0;
    end else begin
      if (in_valid && in_ready_o) expected_reports.push_back(keypad_report(in_req));
      if (!in_valid || in_ready_o) begin
        if (key_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_req   <= key_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each report against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_cnt  <= 0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_reports.size() == 0) begin
          note_mismatch("unexpected report", 0, 1);
        end else begin
          next_report = expected_reports.pop_front();
          if (out_rsp_o.key_valid !== next_report.key_valid)
            note_mismatch("key_valid", next_report.key_valid, out_rsp_o.key_valid);
          if (out_rsp_o.key_code !== next_report.key_code)
            note_mismatch("key_code", next_report.key_code, out_rsp_o.key_code);
          if (out_rsp_o.key_held !== next_report.key_held)
            note_mismatch("key_held", next_report.key_held, out_rsp_o.key_held);
          if (out_rsp_o.any_held !== next_report.any_held)
            note_mismatch("any_held", next_report.any_held, out_rsp_o.any_held);
          if (out_rsp_o.queue_fill !== next_report.queue_fill)
            note_mismatch("queue_fill", next_report.queue_fill, out_rsp_o.queue_fill);
        end
      end
      // long hold-off so the block backs up into its input
      if (hold_req) hold_cnt <= HOLD_OFF_CYCLES;
      else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
      out_ready <= !hold_req && (hold_cnt == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // hard limit on run time
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // stimulus phases and end of run
  initial begin
    int unsigned idle_pct [4];
    int unsigned stall_pct [4];
    idle_pct  = '{0, 79, 0, 16};
    stall_pct = '{0, 0, 79, 16};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty pop, bottom-row and top-row presses, holds, diagonals
    add_req(kspf_pkg::FUNC_POP, 16'h0000, 4'd0);
    add_req(kspf_pkg::FUNC_SCAN, 16'hFFFF, 4'd15);
    add_req(kspf_pkg::FUNC_SCAN, 16'hFFFF, 4'd0);
    add_req(kspf_pkg::FUNC_SCAN, 16'h000F, 4'd0);
    add_req(kspf_pkg::FUNC_SCAN, 16'h0001, 4'd0);
    add_req(kspf_pkg::FUNC_SCAN, 16'h0000, 4'd3);
    repeat (9) add_req(kspf_pkg::FUNC_POP, 16'hFFFF, 4'd15);
    add_req(kspf_pkg::FUNC_SCAN, 16'h0110, 4'd8);
    add_req(kspf_pkg::FUNC_SCAN, 16'h8421, 4'd5);
    add_req(kspf_pkg::FUNC_SCAN, 16'h1248, 4'd12);
    add_req(kspf_pkg::FUNC_SCAN, 16'h1248, 4'd9);
    add_req(kspf_pkg::FUNC_POP, 16'h5555, 4'd6);
    add_req(kspf_pkg::FUNC_POP, 16'hAAAA, 4'd3);
    add_req(kspf_pkg::FUNC_SCAN, 16'h0000, 4'd0);
    add_req(kspf_pkg::FUNC_POP, 16'h0000, 4'd0);

    for (int ph = 0; ph < 4; ph++) begin
      @(posedge clk_i);
      send_idle_pct  <= idle_pct[ph];
      recv_stall_pct <= stall_pct[ph];
      add_random_traffic(ph == 0 ? 240 : 265);
      if (ph == 0) begin
        hold_req <= 1'b1;
        @(posedge clk_i);
        hold_req <= 1'b0;
      end
      while (key_requests.size() != 0 || in_valid || expected_reports.size() != 0)
        @(posedge clk_i);
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
